>>> rtl/core/vgu_pkg.sv
// ----------------------------------------------------------------------------
// vgu_pkg
// Shared types, codes and rounding helpers for the vector geometry unit.
// ----------------------------------------------------------------------------
package vgu_pkg;

	// stream widths, fields packed from bit 0 up and padded to whole bytes
	localparam int IN_W  = 296;
	localparam int OUT_W = 136;

	// item queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// iteration counts of the shared arithmetic units
	localparam int DIV_ITERS = 48;
	localparam int SQ_ITERS  = 34;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_SCALE   = 4'd2,
		OP_DIV     = 4'd3,
		OP_DOT     = 4'd4,
		OP_LENSQ   = 4'd5,
		OP_LEN     = 4'd6,
		OP_NORM    = 4'd7,
		OP_CROSS   = 4'd8,
		OP_REFLECT = 4'd9,
		OP_REFRACT = 4'd10
	} op_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SAT  = 2'd1;
	localparam logic [1:0] STAT_ZERO = 2'd2;
	localparam logic [1:0] STAT_TIR  = 2'd3;

	typedef enum logic [3:0] {
		BK_IDLE = 4'b0001,
		BK_RUN  = 4'b0010,
		BK_WAIT = 4'b0100,
		BK_DONE = 4'b1000
	} bk_state_t;

	// one classified item as it sits in the queue
	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] sc;
		logic [30:0]        n1;
		logic [30:0]        n2;
		logic               bad_op;
		logic               zero_div;
	} vgu_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] rs;
		logic [31:0] rz;
		logic [31:0] ry;
		logic [31:0] rx;
	} vgu_res_t;

	typedef struct packed {
		logic               start;
		logic signed [48:0] num;
		logic signed [34:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [49:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [67:0] rad;
	} sqrt_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [33:0] root;
	} sqrt_rsp_t;

	localparam logic signed [67:0] SMAX = 68'sd2147483647;
	localparam logic signed [67:0] SMIN = -68'sd2147483648;

	// clamp to 32 bits, flag in the top bit
	function automatic logic [32:0] sat32(input logic signed [67:0] v);
		if (v > SMAX)
			return {1'b1, 32'h7FFF_FFFF};
		else if (v < SMIN)
			return {1'b1, 32'h8000_0000};
		else
			return {1'b0, v[31:0]};
	endfunction

	// round half up from q32.32 to q16.16, then clamp
	function automatic logic [32:0] rnd16_sat(input logic signed [67:0] v);
		logic signed [67:0] t;
		t = (v + 68'sd32768) >>> 16;
		return sat32(t);
	endfunction

	function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

endpackage

>>> rtl/core/vgu_div.sv
// ----------------------------------------------------------------------------
// vgu_div
// Radix-2 restoring divider, one quotient bit per cycle, rounds to nearest
// with ties away from zero and returns a signed quotient.
// ----------------------------------------------------------------------------
module vgu_div
	import vgu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q, fin_q, done_q, neg_q;
	logic [5:0]  cnt_q;
	logic [47:0] numr_q, quo_q;
	logic [33:0] den_q;
	logic [33:0] rem_q;
	logic signed [49:0] res_q;

	logic [48:0] num_mag;
	logic [34:0] den_mag;
	logic [34:0] trial;
	logic        take;
	logic [48:0] qr;

	// operand magnitudes and one trial subtraction
	always_comb begin
		num_mag = req.num[48] ? 49'(-req.num) : req.num;
		den_mag = req.den[34] ? 35'(-req.den) : req.den;
		trial   = {rem_q, numr_q[47]};
		take    = trial >= {1'b0, den_q};
		qr      = {1'b0, quo_q} + 49'({rem_q, 1'b0} >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_ITERS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			numr_q <= num_mag[47:0];
			den_q  <= den_mag[33:0];
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= req.num[48] ^ req.den[34];
		end else if (busy_q) begin
			numr_q <= {numr_q[46:0], 1'b0};
			quo_q  <= {quo_q[46:0], take};
			rem_q  <= take ? 34'(trial - {1'b0, den_q}) : trial[33:0];
		end else if (fin_q) begin
			res_q <= neg_q ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
		end
	end

	assign rsp.busy = busy_q | fin_q;
	assign rsp.done = done_q;
	assign rsp.quo  = res_q;

endmodule

>>> rtl/core/vgu_sqrt.sv
// ----------------------------------------------------------------------------
// vgu_sqrt
// Digit-by-digit integer square root, one root bit per cycle, rounded to
// nearest from the final remainder.
// ----------------------------------------------------------------------------
module vgu_sqrt
	import vgu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	logic        busy_q, fin_q, done_q;
	logic [5:0]  cnt_q;
	logic [67:0] v_q, r_q, bit_q;
	logic [33:0] root_q;
	logic [67:0] trial;
	logic        take;

	always_comb begin
		trial = r_q + bit_q;
		take  = v_q >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(SQ_ITERS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q   <= req.rad;
			r_q   <= '0;
			bit_q <= 68'h1 << 66;
		end else if (busy_q) begin
			bit_q <= bit_q >> 2;
			if (take) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end else if (fin_q) begin
			root_q <= r_q[33:0] + 34'(v_q > r_q);
		end
	end

	assign rsp.busy = busy_q | fin_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

>>> rtl/core/vgu_front.sv
// ----------------------------------------------------------------------------
// vgu_front
// Input side: unpacks each beat, classifies it (unused opcode, zero divisor)
// and holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
module vgu_front
	import vgu_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	input  logic            pop,
	output logic            head_valid,
	output vgu_item_t       head
);

	vgu_item_t          mem_q [QDEPTH];
	logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QAW:0]       cnt_q;
	vgu_item_t          item;
	logic               push;

	// unpack and classify
	always_comb begin
		item.op       = s_tdata[3:0];
		item.ax       = s_tdata[35:4];
		item.ay       = s_tdata[67:36];
		item.az       = s_tdata[99:68];
		item.bx       = s_tdata[131:100];
		item.by       = s_tdata[163:132];
		item.bz       = s_tdata[195:164];
		item.sc       = s_tdata[227:196];
		item.n1       = s_tdata[258:228];
		item.n2       = s_tdata[289:259];
		item.bad_op   = s_tdata[3:0] > OP_REFRACT;
		item.zero_div = (s_tdata[3:0] == OP_DIV && s_tdata[227:196] == '0) ||
			(s_tdata[3:0] == OP_REFRACT && s_tdata[289:259] == '0);
	end

	assign s_tready   = cnt_q != (QAW + 1)'(QDEPTH);
	assign push       = s_tvalid & s_tready;
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= item;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (QAW + 1)'(push) - (QAW + 1)'(pop);
		end
	end

endmodule

>>> rtl/core/vgu_back.sv
// ----------------------------------------------------------------------------
// vgu_back
// Execution side: a step sequencer drives one shared 33x33 multiplier, an
// accumulator, the divider and the square root unit, then hands the result
// to an output register.
// ----------------------------------------------------------------------------
module vgu_back
	import vgu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  vgu_item_t head,
	output logic      pop,
	output logic      m_tvalid,
	input  logic      m_tready,
	output vgu_res_t  res
);

	bk_state_t          state_q;
	logic [4:0]         step_q;
	vgu_item_t          item_q;
	logic signed [65:0] mul_q;
	logic signed [67:0] acc_q;
	logic signed [31:0] n_q, cosi_q, d_q, k_q, nsq_q;
	logic signed [32:0] om_q;
	logic signed [47:0] ncos_q;
	logic [33:0]        root_q;
	logic [31:0]        res_q [3];
	logic [31:0]        rs_q;
	logic               sat_q;
	logic [1:0]         code_q;
	logic               out_valid_q;
	vgu_res_t           out_q;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	logic signed [31:0] av [3];
	logic signed [31:0] bv [3];
	logic signed [32:0] ma, mb;
	logic signed [67:0] mul68, acc_add, acc_sub, rnd15, ksum, t16;
	logic [32:0]        r16_mul, r16_add, r16_sub, refl, divsat, rootsat, ksat;
	logic [32:0]        addsub [3];
	logic [4:0]         sm1, sm4, sm5;
	logic [1:0]         didx;
	logic signed [31:0] sint2;
	logic               tir, out_free, div_go, sq_go, finish, run;
	logic signed [32:0] om_n;

	vgu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	vgu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// operand views and step offsets
	always_comb begin
		av[0] = item_q.ax;
		av[1] = item_q.ay;
		av[2] = item_q.az;
		bv[0] = item_q.bx;
		bv[1] = item_q.by;
		bv[2] = item_q.bz;
		sm1   = step_q - 5'd1;
		sm4   = step_q - 5'd4;
		sm5   = step_q - 5'd5;
		run   = state_q == BK_RUN;
		didx  = (item_q.op == OP_DIV) ? step_q[1:0] : sm5[1:0];
	end

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (item_q.op)
			OP_SCALE: begin
				if (step_q <= 5'd2) begin
					ma = sx33(av[step_q[1:0]]);
					mb = sx33(item_q.sc);
				end
			end
			OP_DOT: begin
				if (step_q <= 5'd2) begin
					ma = sx33(av[step_q[1:0]]);
					mb = sx33(bv[step_q[1:0]]);
				end
			end
			OP_LENSQ, OP_LEN, OP_NORM: begin
				if (step_q <= 5'd2) begin
					ma = sx33(av[step_q[1:0]]);
					mb = sx33(av[step_q[1:0]]);
				end
			end
			OP_CROSS: begin
				unique case (step_q)
					5'd0: begin ma = sx33(item_q.ay); mb = sx33(item_q.bz); end
					5'd1: begin ma = sx33(item_q.az); mb = sx33(item_q.by); end
					5'd2: begin ma = sx33(item_q.az); mb = sx33(item_q.bx); end
					5'd3: begin ma = sx33(item_q.ax); mb = sx33(item_q.bz); end
					5'd4: begin ma = sx33(item_q.ax); mb = sx33(item_q.by); end
					5'd5: begin ma = sx33(item_q.ay); mb = sx33(item_q.bx); end
					default: ;
				endcase
			end
			OP_REFLECT: begin
				if (step_q <= 5'd2) begin
					ma = sx33(bv[step_q[1:0]]);
					mb = sx33(av[step_q[1:0]]);
				end else if (step_q >= 5'd4 && step_q <= 5'd6) begin
					ma = sx33(bv[sm4[1:0]]);
					mb = sx33(d_q);
				end
			end
			OP_REFRACT: begin
				unique case (step_q)
					5'd1, 5'd2, 5'd3: begin
						ma = sx33(bv[sm1[1:0]]);
						mb = sx33(av[sm1[1:0]]);
					end
					5'd5:  begin ma = sx33(cosi_q); mb = sx33(cosi_q); end
					5'd6:  begin ma = sx33(n_q); mb = sx33(n_q); end
					5'd7:  begin ma = sx33(n_q); mb = sx33(cosi_q); end
					5'd8:  begin ma = sx33(nsq_q); mb = om_q; end
					5'd11: begin ma = sx33(n_q); mb = sx33(item_q.ax); end
					5'd12: begin ma = sx33(k_q); mb = sx33(item_q.bx); end
					5'd13: begin ma = sx33(n_q); mb = sx33(item_q.ay); end
					5'd14: begin ma = sx33(k_q); mb = sx33(item_q.by); end
					5'd15: begin ma = sx33(n_q); mb = sx33(item_q.az); end
					5'd16: begin ma = sx33(k_q); mb = sx33(item_q.bz); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// rounding, clamping and small adders after the product register
	always_comb begin
		mul68   = {{2{mul_q[65]}}, mul_q};
		acc_add = acc_q + mul68;
		acc_sub = acc_q - mul68;
		r16_mul = rnd16_sat(mul68);
		r16_add = rnd16_sat(acc_add);
		r16_sub = rnd16_sat(acc_sub);
		t16     = (mul68 + 68'sd32768) >>> 16;
		rnd15   = (mul68 + 68'sd16384) >>> 15;
		refl    = sat32({{36{av[sm5[1:0]][31]}}, av[sm5[1:0]]} - rnd15);
		divsat  = sat32({{18{div_rsp.quo[49]}}, div_rsp.quo});
		rootsat = sat32({34'b0, root_q});
		ksum    = {{20{ncos_q[47]}}, ncos_q} + {34'b0, root_q};
		ksat    = sat32(ksum);
		sint2   = r16_mul[31:0];
		tir     = sint2 > 32'sd65536;
		om_n    = 33'sd65536 - sx33(r16_mul[31:0]);
		for (int i = 0; i < 3; i++) begin
			if (item_q.op == OP_SUB)
				addsub[i] = sat32({{36{av[i][31]}}, av[i]} - {{36{bv[i][31]}}, bv[i]});
			else
				addsub[i] = sat32({{36{av[i][31]}}, av[i]} + {{36{bv[i][31]}}, bv[i]});
		end
	end

	// unit launches and the last step of each operation
	always_comb begin
		div_go = run && ((item_q.op == OP_DIV && step_q <= 5'd2) ||
			(item_q.op == OP_NORM && step_q >= 5'd5 && step_q <= 5'd7) ||
			(item_q.op == OP_REFRACT && step_q == 5'd0));
		sq_go = run && (((item_q.op == OP_LEN || item_q.op == OP_NORM) &&
			step_q == 5'd4 && !(item_q.op == OP_NORM && acc_q == '0)) ||
			(item_q.op == OP_REFRACT && step_q == 5'd9 && !tir));
		unique case (item_q.op)
			OP_ADD, OP_SUB:             finish = step_q == 5'd0;
			OP_SCALE, OP_DIV:           finish = step_q == 5'd3;
			OP_DOT, OP_LENSQ:           finish = step_q == 5'd3;
			OP_LEN:                     finish = step_q == 5'd5;
			OP_NORM:                    finish = (step_q == 5'd4 && acc_q == '0) ||
				step_q == 5'd8;
			OP_CROSS:                   finish = step_q == 5'd6;
			OP_REFLECT:                 finish = step_q == 5'd7;
			OP_REFRACT:                 finish = (step_q == 5'd9 && tir) ||
				step_q == 5'd17;
			default:                    finish = 1'b1;
		endcase
		finish = finish & run;

		div_req.start = div_go;
		div_req.num   = (item_q.op == OP_REFRACT) ? {2'b0, item_q.n1, 16'b0} :
			{{1{av[didx][31]}}, av[didx], 16'b0};
		unique case (item_q.op)
			OP_DIV:  div_req.den = {{3{item_q.sc[31]}}, item_q.sc};
			OP_NORM: div_req.den = {1'b0, root_q};
			default: div_req.den = {4'b0, item_q.n2};
		endcase
		sq_req.start = sq_go;
		sq_req.rad   = (item_q.op == OP_REFRACT) ?
			{19'b0, 33'(33'sd65536 - sx33(sint2)), 16'b0} : acc_q;
	end

	assign out_free = !out_valid_q || m_tready;
	assign pop      = head_valid &&
		(state_q == BK_IDLE || (state_q == BK_DONE && out_free));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (pop) begin
						state_q <= (head.bad_op || head.zero_div) ? BK_DONE : BK_RUN;
						step_q  <= '0;
					end
				end
				BK_RUN: begin
					if (div_go || sq_go)
						state_q <= BK_WAIT;
					else if (finish)
						state_q <= BK_DONE;
					else
						step_q <= step_q + 5'd1;
				end
				BK_WAIT: begin
					if (div_rsp.done || sq_rsp.done) begin
						state_q <= BK_RUN;
						step_q  <= step_q + 5'd1;
					end
				end
				BK_DONE: begin
					if (out_free) begin
						if (pop) begin
							state_q <= (head.bad_op || head.zero_div) ? BK_DONE : BK_RUN;
							step_q  <= '0;
						end else begin
							state_q <= BK_IDLE;
						end
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	// shared multiplier
	always_ff @(posedge clk) begin
		mul_q <= ma * mb;
	end

	// working registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q   <= head;
			res_q[0] <= '0;
			res_q[1] <= '0;
			res_q[2] <= '0;
			rs_q     <= '0;
			sat_q    <= 1'b0;
			code_q   <= head.zero_div ? STAT_ZERO : STAT_OK;
		end else if (state_q == BK_WAIT) begin
			if (div_rsp.done) begin
				if (item_q.op == OP_REFRACT) begin
					n_q <= divsat[31:0];
				end else begin
					res_q[didx] <= divsat[31:0];
				end
				sat_q <= sat_q | divsat[32];
			end
			if (sq_rsp.done)
				root_q <= sq_rsp.root;
		end else if (run) begin
			unique case (item_q.op)
				OP_ADD, OP_SUB: begin
					res_q[0] <= addsub[0][31:0];
					res_q[1] <= addsub[1][31:0];
					res_q[2] <= addsub[2][31:0];
					sat_q    <= sat_q | addsub[0][32] | addsub[1][32] | addsub[2][32];
				end
				OP_SCALE: begin
					if (step_q >= 5'd1) begin
						res_q[sm1[1:0]] <= r16_mul[31:0];
						sat_q           <= sat_q | r16_mul[32];
					end
				end
				OP_DOT, OP_LENSQ, OP_LEN, OP_NORM, OP_REFLECT: begin
					unique case (step_q)
						5'd1: acc_q <= mul68;
						5'd2: acc_q <= acc_add;
						5'd3: begin
							if (item_q.op == OP_DOT || item_q.op == OP_LENSQ) begin
								rs_q  <= r16_add[31:0];
								sat_q <= sat_q | r16_add[32];
							end else if (item_q.op == OP_REFLECT) begin
								d_q   <= r16_add[31:0];
								sat_q <= sat_q | r16_add[32];
							end else begin
								acc_q <= acc_add;
							end
						end
						5'd4: begin
							if (item_q.op == OP_NORM && acc_q == '0)
								code_q <= STAT_ZERO;
						end
						5'd5, 5'd6, 5'd7: begin
							if (item_q.op == OP_LEN) begin
								rs_q  <= rootsat[31:0];
								sat_q <= sat_q | rootsat[32];
							end else if (item_q.op == OP_REFLECT) begin
								res_q[sm5[1:0]] <= refl[31:0];
								sat_q           <= sat_q | refl[32];
							end
						end
						default: ;
					endcase
				end
				OP_CROSS: begin
					unique case (step_q)
						5'd1, 5'd3, 5'd5: acc_q <= mul68;
						5'd2: begin res_q[0] <= r16_sub[31:0]; sat_q <= sat_q | r16_sub[32]; end
						5'd4: begin res_q[1] <= r16_sub[31:0]; sat_q <= sat_q | r16_sub[32]; end
						5'd6: begin res_q[2] <= r16_sub[31:0]; sat_q <= sat_q | r16_sub[32]; end
						default: ;
					endcase
				end
				OP_REFRACT: begin
					unique case (step_q)
						5'd2, 5'd12, 5'd14, 5'd16: acc_q <= mul68;
						5'd3: acc_q <= acc_add;
						5'd4: begin cosi_q <= r16_add[31:0]; sat_q <= sat_q | r16_add[32]; end
						5'd6: begin om_q <= om_n; sat_q <= sat_q | r16_mul[32]; end
						5'd7: begin nsq_q <= r16_mul[31:0]; sat_q <= sat_q | r16_mul[32]; end
						5'd8: ncos_q <= t16[47:0];
						5'd9: begin
							sat_q <= sat_q | r16_mul[32];
							if (tir)
								code_q <= STAT_TIR;
						end
						5'd10: begin k_q <= ksat[31:0]; sat_q <= sat_q | ksat[32]; end
						5'd13: begin res_q[0] <= r16_sub[31:0]; sat_q <= sat_q | r16_sub[32]; end
						5'd15: begin res_q[1] <= r16_sub[31:0]; sat_q <= sat_q | r16_sub[32]; end
						5'd17: begin res_q[2] <= r16_sub[31:0]; sat_q <= sat_q | r16_sub[32]; end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_DONE && out_free) begin
			if (code_q != STAT_OK) begin
				out_q.rx     <= '0;
				out_q.ry     <= '0;
				out_q.rz     <= '0;
				out_q.rs     <= '0;
				out_q.status <= code_q;
			end else begin
				out_q.rx     <= res_q[0];
				out_q.ry     <= res_q[1];
				out_q.rz     <= res_q[2];
				out_q.rs     <= rs_q;
				out_q.status <= sat_q ? STAT_SAT : STAT_OK;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign res      = out_q;

	// checks
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("item taken from an empty queue");

	a_wait_unit_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_WAIT |-> div_rsp.busy || div_rsp.done || sq_rsp.busy || sq_rsp.done)
		else $error("sequencer waits on no active unit");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == STAT_ZERO || out_q.status == STAT_TIR) |->
		out_q.rx == '0 && out_q.ry == '0 && out_q.rz == '0 && out_q.rs == '0)
		else $error("error result carries nonzero data");

endmodule

>>> rtl/core/vector3_geometry_unit.sv
// ----------------------------------------------------------------------------
// vector3_geometry_unit
// Q16.16 three-component vector unit: add, sub, scale, divide, dot, squared
// length, length, normalize, cross, reflect and refract, one result a beat.
//
// channel   dir   tdata fields, low bit first
// s_*       in    op 4, ax ay az bx by bz scalar 32 each, index_from 31,
//                 index_to 31, zero pad to 296
// m_*       out   rx ry rz rs 32 each, status 2, zero pad to 136
//
// back end: refract ends early on total internal reflection and normalize
// on a zero length; a zero divisor or an unused opcode skips the steps;
// each divider launch runs 48 quotient steps and each square root launch
// 34 root steps while the back end waits for the result.
// a four-beat queue takes input while the back end works or its output waits.
// reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vector3_geometry_unit
	import vgu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // op, ax, ay, az, bx, by, bz, scalar, index_from, index_to
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // rx, ry, rz, rs, status
);

	logic      head_valid, pop;
	vgu_item_t head;
	vgu_res_t  res;

	vgu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	vgu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.res        (res)
	);

	// result beat packing
	assign m_tdata = {6'b0, res.status, res.rs, res.rz, res.ry, res.rx};

endmodule
